FILE: rtl/rbq_pkg.sv
// Package for the reorder buffer queue: depth, derived widths, action and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rbq_pkg;

  localparam int ROB_DEPTH = 32;
  localparam int PTR_W     = $clog2(ROB_DEPTH);
  localparam int CNT_W     = 6;   // occupancy field width, holds 0..ROB_DEPTH

  localparam int PC_W    = 16;
  localparam int ARCH_W  = 5;
  localparam int PHYS_W  = 6;
  localparam int VALUE_W = 32;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_RETIRE  = 2'd1;
  localparam logic [1:0] ACT_LOOKUP  = 2'd2;
  localparam logic [1:0] ACT_DEQUEUE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ROB_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ROB_DEPTH);

  typedef struct packed {
    logic load_in;   // capture the accepted input word
    logic exec;      // apply the action to pointers and store
    logic look_rd;   // read the physical destination of the lookup match
    logic head_rd;   // read the head entry and load the output register
  } rbq_cmd_t;

  typedef struct packed {
    logic is_lookup;
  } rbq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/rbq_ctrl.sv
// Controller of the reorder buffer queue: sequences execute, lookup read and
// head read, and owns the handshakes. Depends on rbq_pkg.
`default_nettype none

module rbq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire rbq_pkg::rbq_stat_t stat,
  output rbq_pkg::rbq_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_HEAD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    s_tready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.is_lookup ? S_LOOK : S_HEAD;
      end
      S_LOOK: begin
        cmd.look_rd = 1'b1;
        state_next  = S_HEAD;
      end
      S_HEAD: begin
        if (out_free) begin
          cmd.head_rd = 1'b1;
          s_tready    = 1'b1;
          cmd.load_in = s_tvalid;
          state_next  = s_tvalid ? S_EXEC : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.head_rd) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rbq_datapath.sv
// Datapath of the reorder buffer queue: entry store, pointers, pc match,
// result and output registers. Depends on rbq_pkg.
`default_nettype none

module rbq_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rbq_pkg::rbq_cmd_t cmd,
  output rbq_pkg::rbq_stat_t     stat,
  input  wire logic [1:0]        in_action,
  input  wire logic [63:0]       in_data,
  output logic [1:0]             out_status,
  output logic [55:0]            out_data
);

  // captured input word
  logic [1:0]                   act;
  logic [rbq_pkg::PC_W-1:0]     in_pc;
  logic [rbq_pkg::ARCH_W-1:0]   in_arch;
  logic [rbq_pkg::PHYS_W-1:0]   in_phys;
  logic                         in_rdy;
  logic [rbq_pkg::VALUE_W-1:0]  in_val;

  // entry store
  logic [rbq_pkg::PC_W-1:0]   pc_store   [rbq_pkg::ROB_DEPTH];
  logic [rbq_pkg::ARCH_W-1:0] arch_store [rbq_pkg::ROB_DEPTH];
  logic [rbq_pkg::PHYS_W-1:0] phys_store [rbq_pkg::ROB_DEPTH];

  logic [rbq_pkg::PTR_W-1:0] head_ptr;
  logic [rbq_pkg::PTR_W-1:0] tail_ptr;
  logic [rbq_pkg::CNT_W-1:0] entry_count;

  // per-item results
  logic [1:0]                  res_status;
  logic                        res_write;
  logic [rbq_pkg::ARCH_W-1:0]  res_index;
  logic [rbq_pkg::VALUE_W-1:0] res_value;
  logic [rbq_pkg::PHYS_W-1:0]  res_look;
  logic [rbq_pkg::PTR_W-1:0]   match_idx;
  logic                        match_hit;

  logic                        full;
  logic                        empty;
  logic                        do_enq;
  logic                        do_pop;
  logic [rbq_pkg::PTR_W-1:0]   match_idx_next;
  logic                        match_hit_next;
  logic [rbq_pkg::PTR_W-1:0]   rd_addr;
  logic [rbq_pkg::PHYS_W-1:0]  rd_phys;

  assign stat.is_lookup = (act == rbq_pkg::ACT_LOOKUP);

  assign full  = (entry_count == rbq_pkg::FULL_CNT);
  assign empty = (entry_count == '0);

  always_comb begin
    do_enq = 1'b0;
    do_pop = 1'b0;
    unique case (act)
      rbq_pkg::ACT_ENQUEUE: do_enq = !full;
      rbq_pkg::ACT_RETIRE:  do_pop = !empty && in_rdy;
      rbq_pkg::ACT_LOOKUP:  ;
      rbq_pkg::ACT_DEQUEUE: do_pop = !empty;
      default: ;
    endcase
  end

  // lowest matching slot wins: scan downward so the last hit is the lowest
  always_comb begin
    match_hit_next = 1'b0;
    match_idx_next = '0;
    for (int i = rbq_pkg::ROB_DEPTH - 1; i >= 0; i--) begin
      if (pc_store[i] == in_pc) begin
        match_hit_next = 1'b1;
        match_idx_next = rbq_pkg::PTR_W'(i);
      end
    end
  end

  assign rd_addr = cmd.look_rd ? match_idx : head_ptr;
  assign rd_phys = phys_store[rd_addr];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act     <= in_action;
      in_pc   <= in_data[15:0];
      in_arch <= in_data[20:16];
      in_phys <= in_data[26:21];
      in_rdy  <= in_data[27];
      in_val  <= in_data[59:28];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr    <= '0;
      tail_ptr    <= '0;
      entry_count <= '0;
      for (int i = 0; i < rbq_pkg::ROB_DEPTH; i++) begin
        pc_store[i]   <= '0;
        arch_store[i] <= '0;
        phys_store[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (do_enq) begin
        pc_store[tail_ptr]   <= in_pc;
        arch_store[tail_ptr] <= in_arch;
        phys_store[tail_ptr] <= in_phys;
        tail_ptr    <= (tail_ptr == rbq_pkg::LAST_SLOT) ? '0 : tail_ptr + 1'b1;
        entry_count <= entry_count + 1'b1;
      end else if (do_pop) begin
        entry_count <= entry_count - 1'b1;
        if (entry_count == rbq_pkg::CNT_W'(1)) begin
          head_ptr <= '0;
          tail_ptr <= '0;
        end else begin
          head_ptr <= (head_ptr == rbq_pkg::LAST_SLOT) ? '0 : head_ptr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      match_idx <= match_idx_next;
      match_hit <= match_hit_next;
      res_look  <= '0;
      res_write <= 1'b0;
      res_index <= '0;
      res_value <= '0;
      priority if (act == rbq_pkg::ACT_ENQUEUE) begin
        res_status <= full ? rbq_pkg::ST_FULL : rbq_pkg::ST_OK;
      end else if (act == rbq_pkg::ACT_LOOKUP) begin
        res_status <= rbq_pkg::ST_OK;
      end else if (empty) begin
        res_status <= rbq_pkg::ST_EMPTY;
      end else if (act == rbq_pkg::ACT_RETIRE && !in_rdy) begin
        res_status <= rbq_pkg::ST_NOT_READY;
      end else begin
        res_status <= rbq_pkg::ST_OK;
        if (act == rbq_pkg::ACT_RETIRE) begin
          res_write <= 1'b1;
          res_index <= arch_store[head_ptr];
          res_value <= in_val;
        end
      end
    end
    if (cmd.look_rd) begin
      res_look <= match_hit ? rd_phys : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      out_status <= res_status;
      out_data   <= {entry_count,
                     empty ? {rbq_pkg::PHYS_W{1'b0}} : rd_phys,
                     res_look, res_value, res_index, res_write};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/reorder_buffer_queue.sv
// Top level of the reorder buffer queue: controller plus datapath, stream
// ports and a few checks. Depends on rbq_pkg, rbq_ctrl and rbq_datapath.
//
//  channel  | dir | handshake          | tuser        | tdata
//  ---------+-----+--------------------+--------------+---------------------------
//  s        | in  | s_tvalid/s_tready  | action       | pc,dest_arch,dest_phys,..
//  m        | out | m_tvalid/m_tready  | status       | arch_write..occupancy
//
// Each item steps through execute (apply the action and match the pc over all
// slots), for a lookup only the lookup read of the physical destination, and
// the head read of the head entry, all through the single read port of the
// physical destination store.
// Reset clears pointers, count and the whole entry store at once.
// A new word is taken while the previous result still waits in the output
// register; the block stalls at the head read until that register is free.
`default_nettype none

module reorder_buffer_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [1:0]  s_tuser,   // action
  input  wire logic [63:0] s_tdata,   // pc[15:0], dest_arch[20:16], dest_phys[26:21],
                                      // prf_ready[27], prf_value[59:28], zero[63:60]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [1:0]       m_tuser,   // status
  output logic [55:0]      m_tdata    // arch_write[0], arch_index[5:1],
                                      // arch_value[37:6], lookup_phys[43:38],
                                      // head_phys[49:44], occupancy[55:50]
);

  rbq_pkg::rbq_cmd_t  cmd;
  rbq_pkg::rbq_stat_t stat;

  rbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (s_tuser),
    .in_data    (s_tdata),
    .out_status (m_tuser),
    .out_data   (m_tdata)
  );

  // a dropped enqueue only happens with every slot held
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rbq_pkg::ST_FULL |-> m_tdata[55:50] == rbq_pkg::FULL_CNT)
    else $error("full status with occupancy below depth");

  // an empty report leaves the queue empty with no head entry
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rbq_pkg::ST_EMPTY |-> m_tdata[55:44] == 12'd0)
    else $error("empty status with entries or head");

  // an architectural write comes only from a successful retire
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tuser == rbq_pkg::ST_OK)
    else $error("architectural write with error status");

  // occupancy never goes past the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[55:50] <= rbq_pkg::FULL_CNT)
    else $error("occupancy above depth");

endmodule

`default_nettype wire

FILE: sim/rbq_checker.sv
// Scoreboard for the reorder buffer queue: watches both stream channels,
// predicts each result word from its own copy of the queue and compares.
// Depends on rbq_pkg.

module rbq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [1:0]  s_tuser,   // action
  input  logic [63:0] s_tdata,   // pc, dest_arch, dest_phys, prf_ready, prf_value, zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [1:0]  m_tuser,   // status
  input  logic [55:0] m_tdata,   // arch_write, arch_index, arch_value, lookup_phys,
                                 // head_phys, occupancy
  output int          fail_count,
  output int          pending_count,
  output int          checked_count,
  output int          retire_seen,
  output int          full_seen,
  output int          empty_seen,
  output int          not_ready_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Same bit order as {m_tuser, m_tdata}.
  typedef struct packed {
    logic [1:0]                  status;
    logic [rbq_pkg::CNT_W-1:0]   occupancy;
    logic [rbq_pkg::PHYS_W-1:0]  head_phys;
    logic [rbq_pkg::PHYS_W-1:0]  lookup_phys;
    logic [rbq_pkg::VALUE_W-1:0] arch_value;
    logic [rbq_pkg::ARCH_W-1:0]  arch_index;
    logic                        arch_write;
  } rob_result_t;

  logic [rbq_pkg::PC_W-1:0]   pc_mem   [rbq_pkg::ROB_DEPTH];
  logic [rbq_pkg::ARCH_W-1:0] arch_mem [rbq_pkg::ROB_DEPTH];
  logic [rbq_pkg::PHYS_W-1:0] phys_mem [rbq_pkg::ROB_DEPTH];
  logic [rbq_pkg::PTR_W-1:0]  head_slot;
  logic [rbq_pkg::PTR_W-1:0]  tail_slot;
  logic [rbq_pkg::CNT_W-1:0]  held;

  rob_result_t rob_results_due [$];

  function automatic logic [rbq_pkg::PTR_W-1:0] next_slot(
      input logic [rbq_pkg::PTR_W-1:0] slot);
    return (slot == rbq_pkg::LAST_SLOT) ? '0 : slot + 1'b1;
  endfunction

  function automatic void pop_head();
    held = held - 1'b1;
    if (held == '0) begin
      head_slot = '0;
      tail_slot = '0;
    end else begin
      head_slot = next_slot(head_slot);
    end
  endfunction

  function automatic rob_result_t step_rob(input logic [1:0] act, input logic [63:0] word);
    rob_result_t                 r;
    logic [rbq_pkg::PC_W-1:0]    pc;
    logic [rbq_pkg::ARCH_W-1:0]  arch;
    logic [rbq_pkg::PHYS_W-1:0]  phys;
    logic                        ready;
    logic [rbq_pkg::VALUE_W-1:0] value;
    bit                          found;
    pc    = word[15:0];
    arch  = word[20:16];
    phys  = word[26:21];
    ready = word[27];
    value = word[59:28];
    r = '0;
    r.status = rbq_pkg::ST_OK;
    case (act)
      rbq_pkg::ACT_ENQUEUE: begin
        if (held == rbq_pkg::FULL_CNT) begin
          r.status = rbq_pkg::ST_FULL;
        end else begin
          pc_mem[tail_slot]   = pc;
          arch_mem[tail_slot] = arch;
          phys_mem[tail_slot] = phys;
          tail_slot = next_slot(tail_slot);
          held = held + 1'b1;
        end
      end
      rbq_pkg::ACT_RETIRE: begin
        if (held == '0) begin
          r.status = rbq_pkg::ST_EMPTY;
        end else if (!ready) begin
          r.status = rbq_pkg::ST_NOT_READY;
        end else begin
          r.arch_write = 1'b1;
          r.arch_index = arch_mem[head_slot];
          r.arch_value = value;
          pop_head();
        end
      end
      rbq_pkg::ACT_LOOKUP: begin
        // every slot counts, stale ones too; lowest index wins
        found = 1'b0;
        for (int i = 0; i < rbq_pkg::ROB_DEPTH; i++) begin
          if (!found && pc_mem[i] == pc) begin
            found = 1'b1;
            r.lookup_phys = phys_mem[i];
          end
        end
      end
      default: begin
        if (held == '0) r.status = rbq_pkg::ST_EMPTY;
        else pop_head();
      end
    endcase
    r.head_phys = (held != '0) ? phys_mem[head_slot] : '0;
    r.occupancy = held;
    return r;
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_result(input rob_result_t want, input rob_result_t got);
    bit ok;
    ok = field_ok("status", want.status, got.status)
       & field_ok("arch_write", want.arch_write, got.arch_write)
       & field_ok("arch_index", want.arch_index, got.arch_index)
       & field_ok("arch_value", want.arch_value, got.arch_value)
       & field_ok("lookup_phys", want.lookup_phys, got.lookup_phys)
       & field_ok("head_phys", want.head_phys, got.head_phys)
       & field_ok("occupancy", want.occupancy, got.occupancy);
    if (!ok) fail_count++;
    case (want.status)
      rbq_pkg::ST_FULL:      full_seen++;
      rbq_pkg::ST_EMPTY:     empty_seen++;
      rbq_pkg::ST_NOT_READY: not_ready_seen++;
      default:               if (want.arch_write) retire_seen++;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    rob_result_t got;
    rob_result_t want;
    if (rst) begin
      for (int i = 0; i < rbq_pkg::ROB_DEPTH; i++) begin
        pc_mem[i]   = '0;
        arch_mem[i] = '0;
        phys_mem[i] = '0;
      end
      head_slot = '0;
      tail_slot = '0;
      held      = '0;
      rob_results_due.delete();
    end else begin
      // result first: it can never belong to a word taken at this same edge
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (rob_results_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = rob_results_due.pop_front();
          check_result(want, got);
          checked_count++;
        end
      end
      if (s_tvalid && s_tready)
        rob_results_due.push_back(step_rob(s_tuser, s_tdata));
    end
    pending_count = rob_results_due.size();
  end

endmodule

FILE: sim/reorder_buffer_queue_tb.sv
// Top of the reorder buffer queue testbench: clock, reset, stimulus and the
// pass/fail verdict. Depends on rbq_pkg, reorder_buffer_queue and rbq_checker.

module reorder_buffer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1230;  // random words after the directed part
  localparam int CALM_ITEMS   = 150;   // final stretch with no idling on either side
  localparam int DRAIN_CYCLES = 20;    // settle time after the last result

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser  = '0;
  logic [63:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;
  logic [55:0] m_tdata;
  logic        calm     = 1'b0;

  int fail_count, pending_count, checked_count;
  int retire_seen, full_seen, empty_seen, not_ready_seen;
  int words_sent = 0;
  int directed_sent;

  // pc sources: a small pool gives duplicates (first-match priority), the
  // ring of recent enqueues gives lookup hits
  logic [rbq_pkg::PC_W-1:0] pc_pool   [8];
  logic [rbq_pkg::PC_W-1:0] recent_pc [16];
  logic [3:0]               recent_wr = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reorder_buffer_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  rbq_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tuser        (s_tuser),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tuser        (m_tuser),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .retire_seen    (retire_seen),
    .full_seen      (full_seen),
    .empty_seen     (empty_seen),
    .not_ready_seen (not_ready_seen)
  );

  // Offer one word on the slave channel and hold it until it is taken.
  // Called at a falling edge; returns at the falling edge after acceptance,
  // so valid is either kept high with new data or lowered, never both.
  task automatic send_item(input logic [1:0] act, input logic [rbq_pkg::PC_W-1:0] pc,
                           input logic [rbq_pkg::ARCH_W-1:0] arch,
                           input logic [rbq_pkg::PHYS_W-1:0] phys,
                           input logic ready, input logic [rbq_pkg::VALUE_W-1:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tuser  <= act;
    s_tdata  <= {4'b0, value, ready, phys, arch, pc};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    words_sent++;
    if (act == rbq_pkg::ACT_ENQUEUE) begin
      recent_pc[recent_wr] = pc;
      recent_wr = recent_wr + 1'b1;
    end
  endtask

  // Draw one random word; the mode biases the action mix so runs of fill
  // reach a full queue and runs of drain reach an empty one.
  task automatic random_item(input traffic_mode_t mode);
    logic [1:0]               act;
    logic [rbq_pkg::PC_W-1:0] pc;
    int                       roll;
    int                       pick;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 75)      act = rbq_pkg::ACT_ENQUEUE;
        else if (roll < 85) act = rbq_pkg::ACT_LOOKUP;
        else if (roll < 93) act = rbq_pkg::ACT_RETIRE;
        else                act = rbq_pkg::ACT_DEQUEUE;
      end
      MODE_DRAIN: begin
        if (roll < 15)      act = rbq_pkg::ACT_ENQUEUE;
        else if (roll < 30) act = rbq_pkg::ACT_LOOKUP;
        else if (roll < 70) act = rbq_pkg::ACT_RETIRE;
        else                act = rbq_pkg::ACT_DEQUEUE;
      end
      default: begin
        if (roll < 25)      act = rbq_pkg::ACT_ENQUEUE;
        else if (roll < 50) act = rbq_pkg::ACT_RETIRE;
        else if (roll < 75) act = rbq_pkg::ACT_LOOKUP;
        else                act = rbq_pkg::ACT_DEQUEUE;
      end
    endcase
    pick = $urandom_range(0, 9);
    if (act == rbq_pkg::ACT_LOOKUP && pick < 5)
      pc = recent_pc[$urandom_range(0, 15)];
    else if (pick < 7 && (act == rbq_pkg::ACT_LOOKUP || pick < 4))
      pc = pc_pool[$urandom_range(0, 7)];
    else
      pc = rbq_pkg::PC_W'($urandom);
    send_item(act, pc, rbq_pkg::ARCH_W'($urandom), rbq_pkg::PHYS_W'($urandom),
              $urandom_range(0, 3) != 0, rbq_pkg::VALUE_W'($urandom));
  endtask

  // Master-side pacing: random stall bursts, then ready stretches; no stalls
  // once the calm stretch starts.
  initial begin : sink_pacing
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // Hard stop in case the block hangs: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int            left;
    int            run_len;
    traffic_mode_t mode;

    pc_pool[0] = '0;
    pc_pool[1] = '1;
    for (int i = 2; i < 8; i++) pc_pool[i] = rbq_pkg::PC_W'($urandom);
    for (int i = 0; i < 16; i++) recent_pc[i] = '0;

    // hold reset, then release it at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: empty-queue rejects, extremes of every field, stale
    // matches, not-ready head, and pointer return to slot 0 on emptying.
    send_item(rbq_pkg::ACT_RETIRE,  16'h0000, 5'd0,  6'd0,  1'b1, 32'h0000_0000);
    send_item(rbq_pkg::ACT_DEQUEUE, 16'hFFFF, 5'd31, 6'd63, 1'b1, 32'hFFFF_FFFF);
    // cleared slot hits
    send_item(rbq_pkg::ACT_LOOKUP,  16'h0000, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    // miss
    send_item(rbq_pkg::ACT_LOOKUP,  16'hFFFF, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    send_item(rbq_pkg::ACT_ENQUEUE, 16'hFFFF, 5'd31, 6'd63, 1'b0, 32'h0000_0000);
    send_item(rbq_pkg::ACT_ENQUEUE, 16'h1234, 5'd1,  6'd1,  1'b1, 32'hFFFF_FFFF);
    send_item(rbq_pkg::ACT_LOOKUP,  16'hFFFF, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    // head not ready
    send_item(rbq_pkg::ACT_RETIRE,  16'h0000, 5'd0,  6'd0,  1'b0, 32'h1234_5678);
    send_item(rbq_pkg::ACT_RETIRE,  16'h0000, 5'd0,  6'd0,  1'b1, 32'h8000_0000);
    // retired slot still hits
    send_item(rbq_pkg::ACT_LOOKUP,  16'hFFFF, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    // empties the queue
    send_item(rbq_pkg::ACT_RETIRE,  16'hFFFF, 5'd31, 6'd63, 1'b1, 32'h7FFF_FFFF);
    // lands in slot 0
    send_item(rbq_pkg::ACT_ENQUEUE, 16'hAAAA, 5'd10, 6'd21, 1'b0, 32'h0000_0000);
    send_item(rbq_pkg::ACT_ENQUEUE, 16'h5555, 5'd21, 6'd42, 1'b1, 32'hFFFF_FFFF);
    send_item(rbq_pkg::ACT_DEQUEUE, 16'h0000, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    send_item(rbq_pkg::ACT_LOOKUP,  16'h5555, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    send_item(rbq_pkg::ACT_LOOKUP,  16'hAAAA, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    send_item(rbq_pkg::ACT_RETIRE,  16'h0000, 5'd0,  6'd0,  1'b1, 32'hFFFF_FFFF);
    // empty beats not ready
    send_item(rbq_pkg::ACT_RETIRE,  16'h0000, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    send_item(rbq_pkg::ACT_DEQUEUE, 16'h0000, 5'd0,  6'd0,  1'b0, 32'h0000_0000);
    directed_sent = words_sent;

    // Random part: runs of fill, drain and mixed traffic with random content.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      mode    = traffic_mode_t'($urandom_range(0, 2));
      run_len = $urandom_range(20, 80);
      while (run_len > 0 && left > 0) begin
        if (left <= CALM_ITEMS) calm <= 1'b1;
        random_item(mode);
        run_len--;
        left--;
      end
    end
    s_tvalid <= 1'b0;

    // wait out every outstanding result, then give stray words time to show
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d words (%0d directed, rest in fill/drain/mixed runs), checked %0d.",
             words_sent, directed_sent, checked_count);
    $display("Covered %0d retires, %0d full drops, %0d empty rejects, %0d not-ready heads.",
             retire_seen, full_seen, empty_seen, not_ready_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
